// ===== rtl/core/rclb_pkg.sv =====
// Shared types, constants and the pixel blend function of the clipped span blender.
// Used by the top level and its checker; depends on nothing.

package rclb_pkg;

    localparam int FB_WIDTH_DEF  = 128;
    localparam int FB_HEIGHT_DEF = 128;

    localparam int PIX_W   = 16;
    localparam int COUNT_W = 15;
    localparam int CLIP_W  = 7;
    localparam int COORD_W = 18;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [31:0] SPREAD_MASK = 32'h07E0_F81F;
    localparam logic [7:0]  OPAQUE      = 8'hFF;

    localparam logic [CLIP_W-1:0] CLIP_LEFT_RST   = 7'd0;
    localparam logic [CLIP_W-1:0] CLIP_RIGHT_RST  = 7'd127;
    localparam logic [CLIP_W-1:0] CLIP_TOP_RST    = 7'd0;
    localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RST = 7'd127;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_RIGHT  = 2'd1,
        REG_CLIP_TOP    = 2'd2,
        REG_CLIP_BOTTOM = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_PREP,
        S_SPAN,
        S_DRAIN,
        S_RDREQ,
        S_RDWAIT
    } t_state;

    typedef struct packed {
        logic               op;
        logic [15:0]        color_rgb;
        logic [7:0]         alpha;
        logic [7:0]         line_width;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_word;
        logic [COUNT_W-1:0] pixels_covered;
    } t_result;

    function automatic logic [PIX_W-1:0] blend_pixel(
        input logic [PIX_W-1:0] color,
        input logic [PIX_W-1:0] old,
        input logic [7:0]       alpha
    );
        logic [15:0] fs;
        logic [15:0] bs;
        logic [31:0] f;
        logic [31:0] b;
        logic [31:0] prod;
        logic [31:0] nb;
        logic [15:0] w;
        fs   = {color[7:0], color[15:8]};
        bs   = {old[7:0], old[15:8]};
        f    = {fs, fs} & SPREAD_MASK;
        b    = {bs, bs} & SPREAD_MASK;
        prod = (f - b) * {27'd0, alpha[7:3]};
        nb   = (b + {5'd0, prod[31:5]}) & SPREAD_MASK;
        w    = nb[15:0] | nb[31:16];
        if (alpha == OPAQUE) begin
            blend_pixel = color;
        end else begin
            blend_pixel = {w[7:0], w[15:8]};
        end
    endfunction

endpackage

// ===== rtl/core/rgb565_clipped_line_blend_top.sv =====
// Top level of the clipped RGB565 span blender: control, clip registers and frame store.
// Depends on rclb_pkg and rclb_ram.
//
// Usage: an item is taken when start is high and busy is low. A draw item fills a
// horizontal or vertical thick span, clipped to the clip rectangle and the frame, with
// a read-modify-write of every covered pixel. A read item fetches one stored word.
// Each item gives exactly one result, shown on o_result for one cycle with o_done high.
// The receiver cannot stall, so nothing waits on the output side.
// Sequence: a draw runs setup, prep, span and drain, one pixel per cycle in span through
// the single frame store port pair; a draw that covers nothing stops after prep, and a
// read runs setup, prep, read request and read wait. o_done rises in the first cycle that
// busy is low again. Reset: the clip registers return to the full 128 by 128 window and
// the frame store is cleared one word per cycle, busy staying high until it is cleared.
// Clip registers sit on the APB port at byte addresses 0, 4, 8 and 12; the user must
// ensure they are written only while the block is idle; the block does not enforce it.

module rgb565_clipped_line_blend_top
    import rclb_pkg::*;
#(
    parameter int FB_WIDTH  = FB_WIDTH_DEF,
    parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_done,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(FB_WIDTH);
    localparam int YW    = $clog2(FB_HEIGHT);
    localparam logic signed [COORD_W-1:0] X_LIMIT = COORD_W'(FB_WIDTH);
    localparam logic signed [COORD_W-1:0] Y_LIMIT = COORD_W'(FB_HEIGHT);
    localparam logic signed [COORD_W-1:0] X_LAST  = COORD_W'(FB_WIDTH - 1);
    localparam logic signed [COORD_W-1:0] Y_LAST  = COORD_W'(FB_HEIGHT - 1);

    function automatic logic signed [COORD_W-1:0] smin(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        smin = (a < b) ? a : b;
    endfunction

    function automatic logic signed [COORD_W-1:0] smax(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        smax = (a > b) ? a : b;
    endfunction

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_clr_addr, n_clr_addr;
    t_item                       r_item, n_item;
    logic signed [COORD_W-1:0]   r_x0, n_x0, r_x1, n_x1, r_y0, n_y0, r_y1, n_y1;
    logic                        r_ok, n_ok;
    logic [AW-1:0]               r_row_base, n_row_base;
    logic [XW-1:0]               r_x, n_x;
    logic [YW-1:0]               r_y, n_y;
    logic [COUNT_W-1:0]          r_count, n_count;
    logic                        r_p1_valid, n_p1_valid;
    logic [AW-1:0]               r_p1_addr, n_p1_addr;
    logic                        r_done, n_done;
    t_result                     r_result, n_result;
    logic [CLIP_W-1:0]           r_clip_left, r_clip_right, r_clip_top, r_clip_bottom;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [PIX_W-1:0]            mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [PIX_W-1:0]            mem_rdata;

    logic signed [COORD_W-1:0]   sx, sy, ex, ey, exm, eym, h0, h1;
    logic signed [COORD_W-1:0]   lo_x, hi_x, lo_y, hi_y;
    logic [7:0]                  thick;
    logic                        cfg_write;
    t_reg_idx                    cfg_idx;

    rclb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = t_reg_idx'(paddr[3:2]);
    assign pready    = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_CLIP_LEFT:   prdata[CLIP_W-1:0] = r_clip_left;
            REG_CLIP_RIGHT:  prdata[CLIP_W-1:0] = r_clip_right;
            REG_CLIP_TOP:    prdata[CLIP_W-1:0] = r_clip_top;
            REG_CLIP_BOTTOM: prdata[CLIP_W-1:0] = r_clip_bottom;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= CLIP_LEFT_RST;
            r_clip_right  <= CLIP_RIGHT_RST;
            r_clip_top    <= CLIP_TOP_RST;
            r_clip_bottom <= CLIP_BOTTOM_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_CLIP_LEFT:   r_clip_left   <= pwdata[CLIP_W-1:0];
                REG_CLIP_RIGHT:  r_clip_right  <= pwdata[CLIP_W-1:0];
                REG_CLIP_TOP:    r_clip_top    <= pwdata[CLIP_W-1:0];
                REG_CLIP_BOTTOM: r_clip_bottom <= pwdata[CLIP_W-1:0];
            endcase
        end
    end

    always_comb begin
        sx    = {{(COORD_W-16){r_item.start_x[15]}}, r_item.start_x};
        sy    = {{(COORD_W-16){r_item.start_y[15]}}, r_item.start_y};
        ex    = {{(COORD_W-16){r_item.end_x[15]}}, r_item.end_x};
        ey    = {{(COORD_W-16){r_item.end_y[15]}}, r_item.end_y};
        exm   = ex - COORD_W'(1);
        eym   = ey - COORD_W'(1);
        thick = r_item.line_width - 8'd1;
        h0    = COORD_W'(thick[7:1]);
        h1    = h0 + COORD_W'(thick[0]);
        if (r_item.start_y == r_item.end_y) begin
            lo_x = smin(sx, exm);
            hi_x = smax(sx, exm);
            lo_y = sy - h1;
            hi_y = sy + h0;
        end else begin
            lo_x = sx - h1;
            hi_x = sx + h0;
            lo_y = smin(sy, eym);
            hi_y = smax(sy, eym);
        end
    end

    assign mem_raddr = r_row_base + AW'(r_x);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_item     = r_item;
        n_x0       = r_x0;
        n_x1       = r_x1;
        n_y0       = r_y0;
        n_y1       = r_y1;
        n_ok       = r_ok;
        n_row_base = r_row_base;
        n_x        = r_x;
        n_y        = r_y;
        n_count    = r_count;
        n_p1_valid = 1'b0;
        n_p1_addr  = r_p1_addr;
        n_done     = 1'b0;
        n_result   = r_result;
        mem_we     = r_p1_valid;
        mem_waddr  = r_p1_addr;
        mem_wdata  = blend_pixel(r_item.color_rgb, mem_rdata, r_item.alpha);

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_item.op == OP_READ) begin
                    n_ok = (sx >= 0) && (sx < X_LIMIT) && (sy >= 0) && (sy < Y_LIMIT);
                    n_x0 = sx;
                    n_y0 = sy;
                    n_x1 = sx;
                    n_y1 = sy;
                end else begin
                    n_ok = !(r_item.start_x == r_item.end_x && r_item.start_y == r_item.end_y)
                        && (r_item.start_x == r_item.end_x
                            || r_item.start_y == r_item.end_y);
                    n_x0 = smax(COORD_W'(r_clip_left), lo_x);
                    n_x1 = smin(smin(COORD_W'(r_clip_right), hi_x), X_LAST);
                    n_y0 = smax(COORD_W'(r_clip_top), lo_y);
                    n_y1 = smin(smin(COORD_W'(r_clip_bottom), hi_y), Y_LAST);
                end
                n_state = S_PREP;
            end
            S_PREP: begin
                n_row_base = AW'(AW'(r_y0[YW-1:0]) * AW'(FB_WIDTH));
                n_x        = r_x0[XW-1:0];
                n_y        = r_y0[YW-1:0];
                n_count    = '0;
                if (r_item.op == OP_READ) begin
                    n_state = S_RDREQ;
                end else if (!r_ok || (r_x0 > r_x1) || (r_y0 > r_y1)) begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                n_p1_valid = 1'b1;
                n_p1_addr  = mem_raddr;
                n_count    = r_count + COUNT_W'(1);
                if (r_x == r_x1[XW-1:0]) begin
                    if (r_y == r_y1[YW-1:0]) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_x        = r_x0[XW-1:0];
                        n_y        = r_y + YW'(1);
                        n_row_base = r_row_base + AW'(FB_WIDTH);
                    end
                end else begin
                    n_x = r_x + XW'(1);
                end
            end
            S_DRAIN: begin
                n_done                  = 1'b1;
                n_result.pixel_word     = '0;
                n_result.pixels_covered = r_count;
                n_state                 = S_IDLE;
            end
            S_RDREQ: begin
                n_state = S_RDWAIT;
            end
            S_RDWAIT: begin
                n_done                  = 1'b1;
                n_result.pixel_word     = r_ok ? mem_rdata : '0;
                n_result.pixels_covered = '0;
                n_state                 = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_p1_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_p1_valid <= n_p1_valid;
            r_done     <= n_done;
        end
        r_item     <= n_item;
        r_x0       <= n_x0;
        r_x1       <= n_x1;
        r_y0       <= n_y0;
        r_y1       <= n_y1;
        r_ok       <= n_ok;
        r_row_base <= n_row_base;
        r_x        <= n_x;
        r_y        <= n_y;
        r_count    <= n_count;
        r_p1_addr  <= n_p1_addr;
        r_result   <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/core/rclb_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.

module rclb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rclb_checker.sv =====
// Port-level checker for the clipped span blender, bound to the top level.
// Depends on rclb_pkg and rgb565_clipped_line_blend_top.

module rclb_checker
    import rclb_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transaction did not raise busy.");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("Result appeared without a transaction in progress.");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("Result strobe held for more than one cycle.");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.pixel_word == '0 || o_result.pixels_covered == '0))
        else $error("Result carries both a pixel word and a pixel count.");

endmodule

bind rgb565_clipped_line_blend_top rclb_checker u_rclb_checker (.*);
